// ----- hw/rtl/xer_pkg.sv -----
`default_nettype none

package xer_pkg;

	// Parser phases.
	localparam logic [2:0] PH_PASS   = 3'd0;
	localparam logic [2:0] PH_NAME   = 3'd1;
	localparam logic [2:0] PH_HASH   = 3'd2;
	localparam logic [2:0] PH_HEX0   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	localparam logic [4:0] ALL_NAMES = 5'h1F;
	localparam int unsigned NUM_NAMES = 5;
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

	// Error codes.
	localparam logic [1:0] ERR_NAME  = 2'd0;
	localparam logic [1:0] ERR_SYNTAX = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;
	localparam logic [1:0] ERR_EOS   = 2'd3;

	// Kinds of work handed from the parser to the output side.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_UTF8 = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_UX   = 8'h58;

	// One job: a plain byte, a code point to expand, or an error.
	// For a byte the value holds it in the low bits, for an error the code.
	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] value;
		logic [2:0]  count;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Length of each entity name: amp, lt, gt, apos, quot.
	function automatic logic [2:0] name_len(input logic [2:0] k);
		logic [2:0] r;
		case (k)
			3'd0: r = 3'd3;
			3'd1: r = 3'd2;
			3'd2: r = 3'd2;
			3'd3: r = 3'd4;
			3'd4: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Character at a position of a name; zero past its end.
	function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] pos);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			3'd0: case (pos)
				3'd0: r = 8'h61;
				3'd1: r = 8'h6D;
				3'd2: r = 8'h70;
				default: r = 8'h00;
			endcase
			3'd1: case (pos)
				3'd0: r = 8'h6C;
				3'd1: r = 8'h74;
				default: r = 8'h00;
			endcase
			3'd2: case (pos)
				3'd0: r = 8'h67;
				3'd1: r = 8'h74;
				default: r = 8'h00;
			endcase
			3'd3: case (pos)
				3'd0: r = 8'h61;
				3'd1: r = 8'h70;
				3'd2: r = 8'h6F;
				3'd3: r = 8'h73;
				default: r = 8'h00;
			endcase
			3'd4: case (pos)
				3'd0: r = 8'h71;
				3'd1: r = 8'h75;
				3'd2: r = 8'h6F;
				3'd3: r = 8'h74;
				default: r = 8'h00;
			endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Character each name stands for.
	function automatic logic [7:0] name_byte(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0: r = 8'h26;
			3'd1: r = 8'h3C;
			3'd2: r = 8'h3E;
			3'd3: r = 8'h27;
			3'd4: r = 8'h22;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Digit value of a byte, or 16 when it is no digit of the radix.
	function automatic logic [4:0] digit_val(input logic [7:0] b, input logic hex);
		logic [4:0] r;
		r = 5'd16;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = 5'(b - 8'h30);
		end else if (hex && b >= 8'h61 && b <= 8'h66) begin
			r = 5'(b - 8'h57);
		end else if (hex && b >= 8'h41 && b <= 8'h46) begin
			r = 5'(b - 8'h37);
		end
		return r;
	endfunction

	// UTF-8 lead byte prefix for a sequence length.
	function automatic logic [7:0] lead_prefix(input logic [2:0] count);
		logic [7:0] r;
		case (count)
			3'd2: r = 8'hC0;
			3'd3: r = 8'hE0;
			3'd4: r = 8'hF0;
			3'd5: r = 8'hF8;
			3'd6: r = 8'hFC;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/xer_front.sv -----
`default_nettype none

module xer_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire  [7:0]       in_byte,
	input  wire              in_eos,
	input  wire              utf8_mode,
	output logic             push,
	output xer_pkg::job_t    push_job
);
	import xer_pkg::*;

	logic [2:0]  phase_q, n_phase;
	logic [4:0]  cand_q, n_cand;
	logic [2:0]  len_q, n_len;
	logic [30:0] value_q, n_value;
	logic        hex_q, n_hex;
	logic        ovf_q, n_ovf;

	always_comb begin
		logic        clr;
		logic [4:0]  keep;
		logic        hit;
		logic [7:0]  hit_byte;
		logic [4:0]  d;
		logic [35:0] wide;
		logic [35:0] acc;
		logic [2:0]  cnt;

		clr = 1'b0;
		keep = 5'd0;
		hit = 1'b0;
		hit_byte = 8'h00;
		d = digit_val(in_byte, hex_q);
		wide = {5'd0, value_q};
		acc = hex_q ? {1'b0, value_q, 4'd0} + {32'd0, d[3:0]}
			: (wide << 3) + (wide << 1) + {32'd0, d[3:0]};
		if (value_q < 31'h800) begin
			cnt = 3'd2;
		end else if (value_q < 31'h1_0000) begin
			cnt = 3'd3;
		end else if (value_q < 31'h20_0000) begin
			cnt = 3'd4;
		end else if (value_q < 31'h400_0000) begin
			cnt = 3'd5;
		end else begin
			cnt = 3'd6;
		end

		n_phase = phase_q;
		n_cand = cand_q;
		n_len = len_q;
		n_value = value_q;
		n_hex = hex_q;
		n_ovf = ovf_q;
		push = 1'b0;
		push_job = '0;

		for (int k = NUM_NAMES - 1; k >= 0; k--) begin
			if (cand_q[k] && name_len(3'(k)) == len_q) begin
				hit = 1'b1;
				hit_byte = name_byte(3'(k));
			end
			keep[k] = cand_q[k] && (len_q < name_len(3'(k)))
				&& (name_char(3'(k), len_q) == in_byte);
		end

		case (phase_q)
			PH_PASS: begin
				if (in_byte == CH_AMP) begin
					clr = 1'b1;
				end else begin
					push = 1'b1;
					push_job.kind = KIND_BYTE;
					push_job.value = {23'd0, in_byte};
				end
			end
			PH_NAME: begin
				if (in_byte == CH_HASH && len_q == 3'd0) begin
					n_phase = PH_HASH;
				end else if (in_byte == CH_SEMI) begin
					clr = 1'b1;
					push = 1'b1;
					if (hit) begin
						push_job.kind = KIND_BYTE;
						push_job.value = {23'd0, hit_byte};
					end else begin
						push_job.kind = KIND_ERR;
						push_job.value = {29'd0, ERR_NAME};
					end
				end else if (keep == 5'd0) begin
					clr = 1'b1;
					push = 1'b1;
					push_job.kind = KIND_ERR;
					push_job.value = {29'd0, ERR_NAME};
				end else begin
					n_cand = keep;
					n_len = len_q + 3'd1;
				end
			end
			PH_HASH, PH_HEX0, PH_DIGITS: begin
				if (phase_q == PH_HASH && (in_byte == CH_LX || in_byte == CH_UX)) begin
					n_hex = 1'b1;
					n_phase = PH_HEX0;
				end else if (in_byte == CH_SEMI) begin
					clr = 1'b1;
					if (phase_q != PH_DIGITS) begin
						push = 1'b1;
						push_job.kind = KIND_ERR;
						push_job.value = {29'd0, ERR_SYNTAX};
					end else if (ovf_q) begin
						push = 1'b1;
						push_job.kind = KIND_ERR;
						push_job.value = {29'd0, ERR_RANGE};
					end else if (value_q < 31'h80) begin
						push = 1'b1;
						push_job.kind = KIND_BYTE;
						push_job.value = value_q;
					end else if (utf8_mode) begin
						push = 1'b1;
						push_job.kind = KIND_UTF8;
						push_job.value = value_q;
						push_job.count = cnt;
					end
				end else if (d[4]) begin
					clr = 1'b1;
					push = 1'b1;
					push_job.kind = KIND_ERR;
					push_job.value = {29'd0, ERR_SYNTAX};
				end else begin
					if (acc > {5'd0, VALUE_MAX}) begin
						n_ovf = 1'b1;
						n_value = VALUE_MAX;
					end else begin
						n_value = acc[30:0];
					end
					n_phase = PH_DIGITS;
				end
			end
			default: begin
				clr = 1'b1;
				push = 1'b1;
				push_job.kind = KIND_BYTE;
				push_job.value = {23'd0, in_byte};
			end
		endcase

		if (clr) begin
			n_phase = (phase_q == PH_PASS) ? PH_NAME : PH_PASS;
			n_cand = ALL_NAMES;
			n_len = 3'd0;
			n_value = '0;
			n_hex = 1'b0;
			n_ovf = 1'b0;
		end

		// A reference still open at the end of the text gives an end-of-stream error.
		if (in_eos && n_phase != PH_PASS) begin
			push = 1'b1;
			push_job = '0;
			push_job.kind = KIND_ERR;
			push_job.value = {29'd0, ERR_EOS};
			n_phase = PH_PASS;
			n_cand = ALL_NAMES;
			n_len = 3'd0;
			n_value = '0;
			n_hex = 1'b0;
			n_ovf = 1'b0;
		end

		push = push && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PASS;
			cand_q <= ALL_NAMES;
			len_q <= 3'd0;
			value_q <= '0;
			hex_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (in_valid) begin
			phase_q <= n_phase;
			cand_q <= n_cand;
			len_q <= n_len;
			value_q <= n_value;
			hex_q <= n_hex;
			ovf_q <= n_ovf;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/xer_queue.sv -----
`default_nettype none

module xer_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  xer_pkg::job_t    push_job,
	input  wire              pop,
	output xer_pkg::job_t    head_job,
	output xer_pkg::q_stat_t stat
);
	import xer_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/xer_back.sv -----
`default_nettype none

module xer_back (
	input  wire              clk,
	input  wire              arst_n,
	input  xer_pkg::job_t    head_job,
	input  xer_pkg::q_stat_t stat,
	output logic             pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [7:0]       out_byte,
	output logic             out_err,
	output logic [1:0]       out_code,
	output logic             out_last
);
	import xer_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       err_q;
	logic [1:0] code_q;
	logic       last_q;
	logic [2:0] idx_q;

	logic       take, last;
	logic [2:0] count_m1, rem;
	logic [30:0] sh;
	logic [7:0] res_byte;

	assign take = !stat.empty && (!valid_q || out_ready);
	assign count_m1 = head_job.count - 3'd1;
	assign rem = count_m1 - idx_q;
	assign last = (head_job.kind != KIND_UTF8) || (idx_q == count_m1);
	assign pop = take && last;

	always_comb begin
		case (rem)
			3'd0: sh = head_job.value;
			3'd1: sh = head_job.value >> 6;
			3'd2: sh = head_job.value >> 12;
			3'd3: sh = head_job.value >> 18;
			3'd4: sh = head_job.value >> 24;
			3'd5: sh = head_job.value >> 30;
			default: sh = '0;
		endcase
		case (head_job.kind)
			KIND_BYTE: res_byte = head_job.value[7:0];
			KIND_UTF8: res_byte = (idx_q == 3'd0) ? (lead_prefix(head_job.count) | sh[7:0])
				: {2'b10, sh[5:0]};
			default: res_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 3'd0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= res_byte;
			err_q <= (head_job.kind == KIND_ERR);
			code_q <= (head_job.kind == KIND_ERR) ? head_job.value[1:0] : 2'd0;
			last_q <= last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign out_err = err_q;
	assign out_code = code_q;
	assign out_last = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/xml_entity_reference_decoder.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata = in_byte, s_tlast = end_of_stream
// m_*       out        m_tvalid / m_tready  m_tdata = out_byte, m_tuser = {err_code, is_error},
//                                           m_tlast = last_of_run
// cfg_*     in         cfg_valid / cfg_ready cfg_data = utf8_mode
//
// One request per cycle while the queue has room. A plain byte, a named reference or a
// code point below 0x80 gives one result; at or above 0x80 UTF-8 mode gives 2 to 6
// results, one per cycle while the output is ready, and the queue holds up to
// QUEUE_DEPTH - 1 further jobs meanwhile. Each job is queued, then its result registered.
// Reset is asynchronous and active low; it clears the parser and sets UTF-8 mode.
// A stalled output fills the queue and then drops s_tready.
module xml_entity_reference_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [2:0] m_tuser,   // [0] is_error, [2:1] err_code
	output logic       m_tlast,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_data
);
	import xer_pkg::*;

	logic    utf8_q;
	logic    accept;
	logic    push, pop;
	job_t    push_job, head_job;
	q_stat_t stat;
	logic    out_err;
	logic [1:0] out_code;

	// The user must write the mode register only while the decoder is idle; the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			utf8_q <= cfg_data;
		end
	end

	// Input is taken whenever the job queue has room for the request.
	assign s_tready = !stat.full;
	assign accept = s_tvalid && s_tready;

	// The front parses references and hands one job per byte at most.
	xer_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_byte   (s_tdata),
		.in_eos    (s_tlast),
		.utf8_mode (utf8_q),
		.push      (push),
		.push_job  (push_job)
	);

	xer_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (stat)
	);

	// The back end expands each job into output bytes.
	xer_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_err   (out_err),
		.out_code  (out_code),
		.out_last  (m_tlast)
	);

	assign m_tuser = {out_code, out_err};

	// An error result carries a zero byte.
	a_err_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'h00)
		else $error("error result with nonzero byte");

	// An error always closes the run of results of its byte.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("error result not last of run");

	// A good result reports no error code.
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0)
		else $error("error code on good result");

	// A full queue is never empty.
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !stat.empty)
		else $error("queue status inconsistent");

endmodule

`default_nettype wire
